>>> hw/rtl/fltpw_pkg.sv
package fltpw_pkg;

    localparam int unsigned TABLE_WORDS = 4096;
    localparam int unsigned TW_AW       = $clog2(TABLE_WORDS);
    localparam int unsigned IDX_W       = 9;
    localparam int unsigned PAGE_SHIFT  = 12;

    localparam int unsigned VA_W     = 48;
    localparam int unsigned ENTRY_W  = 64;
    localparam int unsigned ROOT_W   = 52;
    localparam int unsigned LEVEL_W  = 3;
    localparam int unsigned STATUS_W = 2;

    localparam int unsigned BIT_PRESENT = 0;
    localparam int unsigned BIT_LARGE   = 7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_WALK  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_WRITE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    localparam logic [LEVEL_W-1:0] LVL_NONE = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_1    = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_2    = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_3    = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_4    = 3'd4;

    // Entry number of a virtual address within the table at the given level
    function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0]    va,
                                                  input logic [LEVEL_W-1:0] lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            LVL_4:   idx = va[PAGE_SHIFT + 3*IDX_W +: IDX_W];
            LVL_3:   idx = va[PAGE_SHIFT + 2*IDX_W +: IDX_W];
            LVL_2:   idx = va[PAGE_SHIFT + IDX_W +: IDX_W];
            default: idx = va[PAGE_SHIFT +: IDX_W];
        endcase
        return idx;
    endfunction

endpackage

>>> hw/rtl/four_level_page_table_walker.sv
// Write item: result registered at the accepting edge and offered the next cycle.
// Walk item: one table memory read per level (single read port, registered read data),
// and the result is loaded into the output register when the walk ends, one item at a time.
// A new item is taken once the previous walk has handed its result to the output register and that register is free.
// Synchronous active-low reset clears control state and the root address;
// table memory contents are undefined until written.
module four_level_page_table_walker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration: root table address
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [51:0]  i_cfg_data,
    // input items
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // word_index[11:0], word_data[75:12], virt_addr[123:76]
    input  logic [0:0]   i_s_tuser,   // command
    // result items
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [79:0]  o_m_tdata,   // level[2:0], entry_index[14:3], entry_value[78:15]
    output logic [1:0]   o_m_tuser    // status
);

    localparam int unsigned AW = fltpw_pkg::TW_AW;

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    t_state r_state;

    logic [fltpw_pkg::ROOT_W-1:0]   r_root;
    logic [fltpw_pkg::VA_W-1:0]     r_va;
    logic [fltpw_pkg::LEVEL_W-1:0]  r_level;
    logic [AW-1:0]                  r_word;

    logic                           r_out_valid;
    logic [fltpw_pkg::STATUS_W-1:0] r_out_status;
    logic [fltpw_pkg::LEVEL_W-1:0]  r_out_level;
    logic [AW-1:0]                  r_out_index;
    logic [fltpw_pkg::ENTRY_W-1:0]  r_out_value;

    logic [fltpw_pkg::ENTRY_W-1:0]  r_mem [fltpw_pkg::TABLE_WORDS];
    logic [fltpw_pkg::ENTRY_W-1:0]  r_rdata;

    logic [11:0]                    in_word_index;
    logic [fltpw_pkg::ENTRY_W-1:0]  in_word_data;
    logic [fltpw_pkg::VA_W-1:0]     in_virt_addr;
    logic                           in_cmd;

    logic                           out_free;
    logic                           out_load;
    logic                           s_accept;
    logic                           wr_en;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic                           stop;
    logic                           absent;
    logic [fltpw_pkg::LEVEL_W-1:0]  next_level;

    assign in_word_index = i_s_tdata[11:0];
    assign in_word_data  = i_s_tdata[75:12];
    assign in_virt_addr  = i_s_tdata[123:76];
    assign in_cmd        = i_s_tuser[0];

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign wr_en      = s_accept && (in_cmd == fltpw_pkg::CMD_WRITE);

    assign o_cfg_ready = 1'b1;

    // level 1 and large pages end the walk as found; large bit wins over present
    assign stop       = (r_level == fltpw_pkg::LVL_1) || r_rdata[fltpw_pkg::BIT_LARGE];
    assign absent     = !stop && !r_rdata[fltpw_pkg::BIT_PRESENT];
    assign next_level = r_level - fltpw_pkg::LVL_1;

    // output register is loaded by a write item or by the end of a walk
    assign out_load   = wr_en || ((r_state == S_EVAL) && (stop || absent) && out_free);

    // table word = next-table frame bits above the entry number, wrapped to memory size
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = {r_rdata[fltpw_pkg::PAGE_SHIFT +: AW-fltpw_pkg::IDX_W],
                   fltpw_pkg::va_index(r_va, next_level)};
        if (r_state == S_IDLE) begin
            rd_en   = s_accept && (in_cmd == fltpw_pkg::CMD_WALK);
            rd_addr = {r_root[fltpw_pkg::PAGE_SHIFT +: AW-fltpw_pkg::IDX_W],
                       fltpw_pkg::va_index(in_virt_addr, fltpw_pkg::LVL_4)};
        end else if (!stop && !absent) begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[in_word_index[AW-1:0]] <= in_word_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_root      <= '0;
            r_level     <= fltpw_pkg::LVL_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_root <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        if (in_cmd == fltpw_pkg::CMD_WRITE) begin
                            r_out_status <= fltpw_pkg::ST_WRITE;
                            r_out_level  <= fltpw_pkg::LVL_NONE;
                            r_out_index  <= in_word_index[AW-1:0];
                            r_out_value  <= in_word_data;
                        end else begin
                            r_va    <= in_virt_addr;
                            r_level <= fltpw_pkg::LVL_4;
                            r_word  <= rd_addr;
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    if (stop || absent) begin
                        // hold the read data until the output register frees
                        if (out_free) begin
                            r_out_status <= absent ? fltpw_pkg::ST_ABSENT
                                                   : fltpw_pkg::ST_FOUND;
                            r_out_level  <= r_level;
                            r_out_index  <= r_word;
                            r_out_value  <= r_rdata;
                            r_level      <= fltpw_pkg::LVL_NONE;
                            r_state      <= S_IDLE;
                        end
                    end else begin
                        r_level <= next_level;
                        r_word  <= rd_addr;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {1'b0, r_out_value, r_out_index, r_out_level};

`ifndef SYNTHESIS
    a_eval_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ((r_level >= fltpw_pkg::LVL_1) &&
                                 (r_level <= fltpw_pkg::LVL_4)))
        else $error("walk level out of range");

    a_write_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == fltpw_pkg::ST_WRITE)) |->
            (o_m_tdata[2:0] == fltpw_pkg::LVL_NONE))
        else $error("write result carries a level");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (in_cmd == fltpw_pkg::CMD_WALK)) |=> !o_s_tready)
        else $error("second item taken before the first was finished");

    a_walk_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (in_cmd == fltpw_pkg::CMD_WALK)) |=> (r_state == S_EVAL))
        else $error("walk item did not start a walk");
`endif

endmodule

>>> sim/four_level_page_table_walker_tb.sv
module four_level_page_table_walker_tb;

    localparam int unsigned TW_AW   = fltpw_pkg::TW_AW;
    localparam int unsigned VA_W    = fltpw_pkg::VA_W;
    localparam int unsigned ROOT_W  = fltpw_pkg::ROOT_W;
    localparam int unsigned IDX_W   = fltpw_pkg::IDX_W;
    localparam int unsigned LEVEL_W = fltpw_pkg::LEVEL_W;
    localparam int unsigned ENTRY_W = fltpw_pkg::ENTRY_W;

    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_CMDS  = 120;

    typedef struct packed {
        logic [fltpw_pkg::STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  level;
        logic [TW_AW-1:0]    entry_index;
        logic [ENTRY_W-1:0]  entry_value;
    } t_walk_result;

    typedef struct packed {
        logic                cmd;
        logic [TW_AW-1:0]    word_index;
        logic [ENTRY_W-1:0]  word_data;
        logic [VA_W-1:0]     virt_addr;
        logic                drain_first;
        t_walk_result        result;
    } t_table_cmd;

    typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN, RDY_SPARSE} t_ready_mode;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [51:0]  i_cfg_data  = '0;
    logic         i_s_tvalid  = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata   = '0;
    logic [0:0]   i_s_tuser   = '0;
    logic         o_m_tvalid;
    logic         i_m_tready  = 1'b0;
    logic [79:0]  o_m_tdata;
    logic [1:0]   o_m_tuser;

    four_level_page_table_walker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the walker state, advanced in the order items are queued
    logic [ENTRY_W-1:0] shadow_table [fltpw_pkg::TABLE_WORDS];
    bit                 shadow_written [fltpw_pkg::TABLE_WORDS];
    logic [ROOT_W-1:0]  shadow_root = '0;

    t_table_cmd   pending_cmds [$];
    t_walk_result due_results [$];
    logic [VA_W-1:0] va_pool [$];
    int  cmd_count = 0;
    bit  hold_next = 0;
    bit  fault_seen = 0;
    int  quiet_cycles = 0;

    // Walk as the block does. hole returns the first never-written word met, or -1.
    function automatic t_walk_result walk_table(input logic [VA_W-1:0] va, output int hole);
        t_walk_result      r;
        logic [ROOT_W-1:0] base;
        logic [IDX_W-1:0]  ix;
        logic [63:0]       wa;
        logic [TW_AW-1:0]  w;
        logic [ENTRY_W-1:0] ent;
        int                lv;
        hole   = -1;
        base   = shadow_root;
        r      = '0;
        r.status = fltpw_pkg::ST_FOUND;
        for (lv = int'(fltpw_pkg::LVL_4); lv >= int'(fltpw_pkg::LVL_1); lv--) begin
            ix = va[fltpw_pkg::PAGE_SHIFT + IDX_W * (lv - 1) +: IDX_W];
            // table word = frame number of base * 512 + entry, wrapping round the memory
            wa = (64'(base[ROOT_W-1:fltpw_pkg::PAGE_SHIFT]) << IDX_W) + 64'(ix);
            w  = wa[TW_AW-1:0];
            if (!shadow_written[w]) begin
                hole = int'(w);
                break;
            end
            ent = shadow_table[w];
            r.level       = LEVEL_W'(lv);
            r.entry_index = w;
            r.entry_value = ent;
            if (lv == int'(fltpw_pkg::LVL_1) || ent[fltpw_pkg::BIT_LARGE])
                break;
            if (!ent[fltpw_pkg::BIT_PRESENT]) begin
                r.status = fltpw_pkg::ST_ABSENT;
                break;
            end
            base = ent[ROOT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ENTRY_W-1:0] rand_entry();
        logic [ENTRY_W-1:0] e;
        e = {$urandom, $urandom};
        // mostly present, now and then large; the rest left fully random
        if ($urandom_range(0, 19) != 0) begin
            e[fltpw_pkg::BIT_PRESENT] = ($urandom_range(0, 9) != 0);
            e[fltpw_pkg::BIT_LARGE]   = ($urandom_range(0, 6) == 0);
        end
        return e;
    endfunction

    task automatic queue_cmd(input t_table_cmd it);
        it.drain_first = hold_next;
        hold_next = 0;
        pending_cmds.push_back(it);
        cmd_count++;
    endtask

    task automatic push_write(input logic [TW_AW-1:0] idx, input logic [ENTRY_W-1:0] data);
        t_table_cmd it;
        it.cmd        = fltpw_pkg::CMD_WRITE;
        it.word_index = idx;
        it.word_data  = data;
        it.virt_addr  = VA_W'({$urandom, $urandom});
        shadow_table[idx]   = data;
        shadow_written[idx] = 1;
        it.result.status      = fltpw_pkg::ST_WRITE;
        it.result.level       = fltpw_pkg::LVL_NONE;
        it.result.entry_index = idx;
        it.result.entry_value = data;
        queue_cmd(it);
    endtask

    // Any word on the path not yet loaded gets a random entry first
    task automatic push_walk(input logic [VA_W-1:0] va);
        t_table_cmd it;
        int hole;
        it.result = walk_table(va, hole);
        while (hole >= 0) begin
            push_write(TW_AW'(hole), rand_entry());
            it.result = walk_table(va, hole);
        end
        it.cmd        = fltpw_pkg::CMD_WALK;
        it.word_index = TW_AW'($urandom);
        it.word_data  = {$urandom, $urandom};
        it.virt_addr  = va;
        queue_cmd(it);
    endtask

    function automatic logic [VA_W-1:0] mk_va(input int i4, input int i3, input int i2,
                                              input int i1);
        return {IDX_W'(i4), IDX_W'(i3), IDX_W'(i2), IDX_W'(i1), 12'h000};
    endfunction

    task automatic write_root(input logic [ROOT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        shadow_root = val;
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_cmds.size() != 0 || i_s_tvalid || due_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_phase(input int n);
        int start, sel, lo;
        bit held;
        logic [VA_W-1:0] va, mask;
        start = cmd_count;
        held  = 0;
        while (cmd_count - start < n) begin
            if (!held && cmd_count - start >= n / 2) begin
                hold_next = 1;
                held = 1;
            end else if ($urandom_range(0, 99) == 0) begin
                hold_next = 1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                push_write(TW_AW'($urandom), rand_entry());
            end else if (sel < 28) begin
                push_write(TW_AW'($urandom), {$urandom, $urandom});
            end else begin
                va = VA_W'({$urandom, $urandom});
                // reuse the upper levels of an earlier walk
                if (sel >= 60 && va_pool.size() != 0) begin
                    lo   = fltpw_pkg::PAGE_SHIFT + IDX_W * $urandom_range(0, 3);
                    mask = (48'd1 << lo) - 48'd1;
                    va   = (va_pool[$urandom_range(0, va_pool.size() - 1)] & ~mask) | (va & mask);
                end
                push_walk(va);
                if (va_pool.size() < 64)
                    va_pool.push_back(va);
                else
                    va_pool[$urandom_range(0, 63)] = va;
            end
        end
    endtask

    // sender: bursts of random length with random gaps
    t_table_cmd on_bus;
    int burst_left = 5;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                due_results.push_back(on_bus.result);
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0 &&
                             !(pending_cmds[0].drain_first && due_results.size() != 0)) begin
                    on_bus = pending_cmds.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {4'b0, on_bus.virt_addr, on_bus.word_data, on_bus.word_index};
                    i_s_tuser  <= on_bus.cmd;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
            fault_seen = 1;
        end
    endtask

    // receiver: ready pattern changes now and then
    t_walk_result want, got;
    t_ready_mode  stall_mode  = RDY_ALWAYS;
    int           mode_cycles = 0;
    logic [7:0]   stall_pat   = 8'hff;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.status      = o_m_tuser;
                got.level       = o_m_tdata[2:0];
                got.entry_index = o_m_tdata[14:3];
                got.entry_value = o_m_tdata[78:15];
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result item, status %h level %h index %h value %h",
                             $time, got.status, got.level, got.entry_index, got.entry_value);
                    fault_seen = 1;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("level", 64'(want.level), 64'(got.level));
                    check_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
                    check_field("entry_value", want.entry_value, got.entry_value);
                end
            end
            if (mode_cycles == 0) begin
                mode_cycles = $urandom_range(20, 150);
                stall_mode  = t_ready_mode'($urandom_range(0, 3));
                stall_pat   = 8'($urandom) | 8'h01;
            end
            mode_cycles--;
            case (stall_mode)
                RDY_ALWAYS:  i_m_tready <= 1'b1;
                RDY_RANDOM:  i_m_tready <= ($urandom_range(0, 3) != 0);
                RDY_PATTERN: i_m_tready <= stall_pat[mode_cycles % 8];
                default:     i_m_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_root('0);

        // directed: field extremes and each way a walk can end
        push_write(0, '0);
        push_write(TW_AW'(fltpw_pkg::TABLE_WORDS - 1), '1);
        push_walk('0);                                  // not present at level 4
        push_write(511, 64'h81);
        push_walk('1);                                  // large at level 4
        push_write(1, 64'h1001);
        push_write(512, 64'h2081);
        push_walk(mk_va(1, 0, 0, 0));                   // large at level 3
        push_write(513, 64'h0);
        push_walk(mk_va(1, 1, 0, 0));                   // not present at level 3
        push_write(2, 64'h2001);
        push_write(1029, 64'h3001);
        push_write(1543, 64'h80);
        push_walk(mk_va(2, 5, 7, 0));                   // large without present, level 2
        push_write(1544, 64'h4001);
        push_write(2057, 64'h0);
        push_walk(mk_va(2, 5, 8, 9) | 48'habc);         // level 1 entry not present
        push_write(1545, 64'h100);
        push_walk(mk_va(2, 5, 9, 0));                   // not present at level 2
        // flag bits above bit 51 must not reach the next table address
        push_write(3, 64'hfff1_2345_6789_d001);
        push_write(2560, '1);
        push_walk(mk_va(3, 0, 0, 0));
        wait_idle();

        write_root('1);
        random_phase(PHASE_CMDS);
        wait_idle();
        write_root(ROOT_W'({$urandom, $urandom}));
        random_phase(PHASE_CMDS);
        wait_idle();
        write_root({40'($urandom), 12'h000});
        random_phase(PHASE_CMDS);
        wait_idle();
        write_root('0);
        random_phase(PHASE_CMDS);
        wait_idle();
        write_root(ROOT_W'({$urandom, $urandom}));
        random_phase(PHASE_CMDS);
        wait_idle();

        repeat (20) @(posedge i_clk);
        if (!fault_seen && due_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
